[hw/rtl/gbms_pkg.sv]
// Shared constants, types and the falloff table for the brush mask stamp.
`timescale 1ns / 1ps

package gbms_pkg;

  // Mask geometry and field widths.
  localparam int MASK_SIZE     = 1024;
  localparam int COORD_BITS    = 10;
  localparam int RADIUS_BITS   = 11;
  localparam int STRENGTH_BITS = 6;
  localparam int MS_BITS       = 8;
  localparam int BYTE_BITS     = 8;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_RADIUS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRENGTH     = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [RADIUS_BITS-1:0]   RADIUS_RESET   = 11'd32;
  localparam logic [STRENGTH_BITS-1:0] STRENGTH_RESET = 6'd4;

  // Mask memory organization: several mask bytes share one memory word.
  localparam int LANES      = 16;
  localparam int LANE_BITS  = $clog2(LANES);
  localparam int WORD_BITS  = LANES * BYTE_BITS;
  localparam int WORDS      = (MASK_SIZE * MASK_SIZE) / LANES;
  localparam int WADDR_BITS = $clog2(WORDS);
  localparam int BADDR_BITS = $clog2(MASK_SIZE * MASK_SIZE);

  // Falloff table.
  localparam int FALLOFF_ENTRIES = 256;
  localparam int IDX_BITS        = $clog2(FALLOFF_ENTRIES);
  localparam int DIV_CNT_BITS    = $clog2(IDX_BITS);
  localparam int FALL_BITS       = 16;

  // Step scaling: a change of one byte step is 65536 * 2 * 1000 / 400 = 5 << 16.
  localparam int STEP_SHIFT  = 16;
  localparam int STEP_ODD    = 5;
  localparam int STEP_DIV    = STEP_ODD << STEP_SHIFT;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + STEP_ODD - 1) / STEP_ODD;
  localparam int PROD_BITS   = FALL_BITS + STRENGTH_BITS + MS_BITS;
  localparam int PADJ_BITS   = PROD_BITS + 1;
  localparam int NUM_BITS    = PADJ_BITS - STEP_SHIFT;
  localparam int RECIP_BITS  = 16;
  localparam int QPROD_BITS  = NUM_BITS + RECIP_BITS;
  localparam int STEP_BITS   = QPROD_BITS - RECIP_SHIFT;

  // Request from the control sequencer to the falloff unit.
  typedef struct packed {
    logic                     go;
    logic [COORD_BITS-1:0]    px;
    logic [COORD_BITS-1:0]    py;
    logic [COORD_BITS-1:0]    cx;
    logic [COORD_BITS-1:0]    cy;
    logic [RADIUS_BITS-1:0]   radius;
    logic [STRENGTH_BITS-1:0] strength;
    logic [MS_BITS-1:0]       ms;
    logic                     erase;
  } fo_req_t;

  // Answer of the falloff unit: a one-cycle done pulse and the byte step.
  typedef struct packed {
    logic                 done;
    logic [STEP_BITS-1:0] step;
  } fo_res_t;

  typedef logic [FALL_BITS-1:0] falloff_tab_t [FALLOFF_ENTRIES];

  // Divides a series term by its small loop index, each arm by a constant.
  function automatic longint unsigned div_k(longint unsigned v, int k);
    longint unsigned r;
    unique case (k)
      1:       r = v;
      2:       r = v / 2;
      3:       r = v / 3;
      4:       r = v / 4;
      5:       r = v / 5;
      6:       r = v / 6;
      7:       r = v / 7;
      8:       r = v / 8;
      9:       r = v / 9;
      10:      r = v / 10;
      11:      r = v / 11;
      12:      r = v / 12;
      13:      r = v / 13;
      14:      r = v / 14;
      default: r = 0;
    endcase
    return r;
  endfunction

  // One table entry: exp(-4 t2) from a Taylor series of exp(-t2/2) squared
  // three times, less one tenth, clamped and rounded to Q0.16.
  function automatic logic [FALL_BITS-1:0] falloff_entry(int i);
    longint unsigned z;
    longint unsigned term;
    longint unsigned e;
    longint          acc;
    longint          f;
    z    = (longint'(i) << 30) / (2 * FALLOFF_ENTRIES);
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      term = (term * z) >> 30;
      term = div_k(term, k);
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (64'sd1 << 30)) begin
      acc = 64'sd1 << 30;
    end
    e = longint'(acc);
    for (int k = 0; k < 3; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    f = longint'(e) - 64'sd107374182;
    if (f < 0) begin
      f = 0;
    end
    f = (f + (64'sd1 << 13)) >>> 14;
    if (f > 65535) begin
      f = 65535;
    end
    return f[FALL_BITS-1:0];
  endfunction

  function automatic falloff_tab_t build_falloff();
    falloff_tab_t t;
    for (int i = 0; i < FALLOFF_ENTRIES; i++) begin
      t[i] = falloff_entry(i);
    end
    return t;
  endfunction

  localparam falloff_tab_t FALLOFF_TAB = build_falloff();

endpackage

[hw/rtl/gbms_mask_ram.sv]
// Single-port-write, single-port-read synchronous RAM holding the mask words.
`timescale 1ns / 1ps

module gbms_mask_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/gbms_falloff.sv]
// Falloff unit: distance, iterative index divide, table lookup and step scaling.
`timescale 1ns / 1ps

module gbms_falloff
  import gbms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  fo_req_t req,
  output fo_res_t res
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_LOOK = 3'd4;
  localparam logic [2:0] F_MUL1 = 3'd5;
  localparam logic [2:0] F_MUL2 = 3'd6;
  localparam logic [2:0] F_DQ   = 3'd7;

  localparam int SQ_BITS  = 2 * COORD_BITS;
  localparam int D2_BITS  = SQ_BITS + 1;
  localparam int R2_BITS  = 2 * RADIUS_BITS;
  localparam int FS_BITS  = FALL_BITS + STRENGTH_BITS;

  logic [2:0]               state;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [COORD_BITS-1:0]    dx;
  logic [COORD_BITS-1:0]    dy;
  logic [RADIUS_BITS-1:0]   rad;
  logic [STRENGTH_BITS-1:0] strength;
  logic [MS_BITS-1:0]       ms;
  logic                     erase;
  logic [SQ_BITS-1:0]       dx2;
  logic [SQ_BITS-1:0]       dy2;
  logic [R2_BITS-1:0]       r2;
  logic [R2_BITS-1:0]       rem;
  logic [IDX_BITS-1:0]      quo;
  logic                     in_rng;
  logic [FALL_BITS-1:0]     fall;
  logic [FS_BITS-1:0]       fs;
  logic [PROD_BITS-1:0]     prod;

  logic [D2_BITS-1:0]       d2;
  logic [R2_BITS:0]         shifted;
  logic                     fits;
  logic [PADJ_BITS-1:0]     padj;
  logic [QPROD_BITS-1:0]    qprod;

  // Squared distance, one restoring divide step and the reciprocal divide.
  always_comb begin
    d2      = {1'b0, dx2} + {1'b0, dy2};
    shifted = {rem, 1'b0};
    fits    = shifted >= {1'b0, r2};
    padj    = erase ? ({1'b0, prod} + PADJ_BITS'(STEP_DIV - 1)) : {1'b0, prod};
    qprod   = {{RECIP_BITS{1'b0}}, padj[PADJ_BITS-1:STEP_SHIFT]}
              * QPROD_BITS'(RECIP);
  end

  // Control sequence of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      cnt      <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.go) begin
            state <= F_SQ;
          end
        end
        F_SQ:   state <= F_SUM;
        F_SUM: begin
          cnt   <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_BITS'(IDX_BITS - 1)) begin
            state <= F_LOOK;
          end
        end
        F_LOOK: state <= F_MUL1;
        F_MUL1: state <= F_MUL2;
        F_MUL2: state <= F_DQ;
        F_DQ: begin
          res.done <= 1'b1;
          state    <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        dx       <= (req.px >= req.cx) ? (req.px - req.cx) : (req.cx - req.px);
        dy       <= (req.py >= req.cy) ? (req.py - req.cy) : (req.cy - req.py);
        rad      <= (req.radius == '0) ? RADIUS_BITS'(1) : req.radius;
        strength <= req.strength;
        ms       <= req.ms;
        erase    <= req.erase;
      end
      F_SQ: begin
        dx2 <= dx * dx;
        dy2 <= dy * dy;
        r2  <= rad * rad;
      end
      F_SUM: begin
        // Beyond the radius the index is out of the table and falloff is zero.
        in_rng <= {1'b0, d2} < r2;
        rem    <= R2_BITS'(d2);
        quo    <= '0;
      end
      F_DIV: begin
        if (fits) begin
          rem <= R2_BITS'(shifted - {1'b0, r2});
        end else begin
          rem <= shifted[R2_BITS-1:0];
        end
        quo <= {quo[IDX_BITS-2:0], fits};
      end
      F_LOOK: fall <= in_rng ? FALLOFF_TAB[quo] : '0;
      F_MUL1: fs   <= fall * strength;
      F_MUL2: prod <= fs * ms;
      F_DQ:   res.step <= qprod[QPROD_BITS-1:RECIP_SHIFT];
      default: ;
    endcase
  end

endmodule

[hw/rtl/gaussian_brush_mask_stamp.sv]
// Top level of the brush mask stamp: control, mask read-modify-write and clearing.
`timescale 1ns / 1ps
// Soft brush stamp on a 1024 x 1024 byte mask.
// Usage: drive one pixel word (pixel_x/y, center_x/y, erase, frame_ms) and
// pulse start; the word is taken at a clock edge where start is high and
// busy is low. One result word (out_x, out_y, new_value) appears for one
// cycle with done high; the receiver must take it then, there is no stall.
// Configuration: cfg_we with cfg_index 0 writes brush_radius, index 1
// writes strength_halves; write only while the block is idle.
// Sequence: the falloff unit runs the square, a restoring divide for the table
// index, the lookup, two multiply stages and the step scaling in turn; busy
// drops in the cycle the result shows, so a new pixel is taken only once the
// last one is through. The mask word is read at accept and written back when
// the step is known; one item is in flight, so no forwarding is needed.
// A pixel outside the mask gives new_value 0 in the cycle after accept.
// Reset: after rst the memory is cleared, 16 bytes a cycle over its 65536
// words, with busy high; registers return to radius 32, strength 4.
module gaussian_brush_mask_stamp
  import gbms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [COORD_BITS-1:0]    pixel_x,
  input  logic [COORD_BITS-1:0]    pixel_y,
  input  logic [COORD_BITS-1:0]    center_x,
  input  logic [COORD_BITS-1:0]    center_y,
  input  logic                     erase,
  input  logic [MS_BITS-1:0]       frame_ms,
  output logic                     done,
  output logic [COORD_BITS-1:0]    out_x,
  output logic [COORD_BITS-1:0]    out_y,
  output logic [BYTE_BITS-1:0]     new_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]               state;
  logic [WADDR_BITS-1:0]    clr_addr;
  logic [RADIUS_BITS-1:0]   brush_radius;
  logic [STRENGTH_BITS-1:0] strength_halves;
  logic [WADDR_BITS-1:0]    word_addr;
  logic [LANE_BITS-1:0]     lane;
  logic                     erase_q;

  logic                     accept;
  logic                     in_mask;
  logic [BADDR_BITS-1:0]    byte_addr;
  fo_req_t                  fo_req;
  fo_res_t                  fo_res;
  logic                     mem_re;
  logic                     mem_we;
  logic [WADDR_BITS-1:0]    mem_waddr;
  logic [WORD_BITS-1:0]     mem_rdata;
  logic [WORD_BITS-1:0]     mem_wdata;
  logic [WORD_BITS-1:0]     word_mod;
  logic [BYTE_BITS-1:0]     old_byte;
  logic [BYTE_BITS-1:0]     new_byte;
  logic [STEP_BITS:0]       paint_sum;

  // Input word handshake and mask address.
  always_comb begin
    busy      = state != ST_IDLE;
    accept    = start && !busy;
    in_mask   = (32'(pixel_x) < MASK_SIZE) && (32'(pixel_y) < MASK_SIZE);
    byte_addr = BADDR_BITS'(32'(pixel_y) * MASK_SIZE + 32'(pixel_x));
  end

  // Request to the falloff unit.
  always_comb begin
    fo_req.go       = accept && in_mask;
    fo_req.px       = pixel_x;
    fo_req.py       = pixel_y;
    fo_req.cx       = center_x;
    fo_req.cy       = center_y;
    fo_req.radius   = brush_radius;
    fo_req.strength = strength_halves;
    fo_req.ms       = frame_ms;
    fo_req.erase    = erase;
  end

  // Byte update with saturation, merged back into the memory word.
  always_comb begin
    old_byte  = mem_rdata[{lane, 3'b000} +: BYTE_BITS];
    paint_sum = {{(STEP_BITS + 1 - BYTE_BITS){1'b0}}, old_byte} + {1'b0, fo_res.step};
    if (erase_q) begin
      new_byte = ({{(STEP_BITS - BYTE_BITS){1'b0}}, old_byte} <= fo_res.step)
                 ? '0 : (old_byte - fo_res.step[BYTE_BITS-1:0]);
    end else begin
      new_byte = (paint_sum > (STEP_BITS + 1)'(255)) ? 8'hFF
                 : paint_sum[BYTE_BITS-1:0];
    end
    word_mod = mem_rdata;
    word_mod[{lane, 3'b000} +: BYTE_BITS] = new_byte;
  end

  // Memory ports: clearing sweep after reset, otherwise read at accept
  // and write back when the step arrives.
  always_comb begin
    mem_re    = fo_req.go;
    mem_we    = (state == ST_CLEAR) || (state == ST_WAIT && fo_res.done);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : word_addr;
    mem_wdata = (state == ST_CLEAR) ? '0 : word_mod;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius    <= RADIUS_RESET;
      strength_halves <= STRENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRUSH_RADIUS: brush_radius    <= cfg_data[RADIUS_BITS-1:0];
        REG_STRENGTH:     strength_halves <= cfg_data[STRENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Control state machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WADDR_BITS'(WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_mask) begin
              state <= ST_WAIT;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_WAIT: begin
          if (fo_res.done) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item context and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_x     <= pixel_x;
      out_y     <= pixel_y;
      word_addr <= byte_addr[BADDR_BITS-1:LANE_BITS];
      lane      <= byte_addr[LANE_BITS-1:0];
      erase_q   <= erase;
      new_value <= '0;
    end else if (state == ST_WAIT && fo_res.done) begin
      new_value <= new_byte;
    end
  end

  gbms_falloff u_falloff (
    .clk (clk),
    .rst (rst),
    .req (fo_req),
    .res (fo_res)
  );

  gbms_mask_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_BITS)
  ) u_mask_ram (
    .clk   (clk),
    .re    (mem_re),
    .raddr (byte_addr[BADDR_BITS-1:LANE_BITS]),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // No result word may appear while the mask is still being cleared.
  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !done)
    else $error("result word during clearing pass");

  // Memory writes come only from the clearing sweep or a finished update.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR) || (state == ST_WAIT && fo_res.done))
    else $error("unexpected mask write");

  // The falloff unit only answers while an item waits for it.
  a_step_when_waiting: assert property (@(posedge clk) disable iff (rst)
    fo_res.done |-> state == ST_WAIT)
    else $error("falloff step with no item pending");

  // A finished step always produces a result word in the next cycle.
  a_step_gives_word: assert property (@(posedge clk) disable iff (rst)
    fo_res.done |=> done)
    else $error("step finished but no result word");

  // An in-mask pixel starts the update and reads its memory word.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && in_mask) |-> mem_re ##1 (state == ST_WAIT))
    else $error("accepted pixel did not start an update");

endmodule

[tb/sv/gaussian_brush_mask_stamp_tb.sv]
// Self-checking testbench for the brush mask stamp: directed table, then random stamp traffic.
`timescale 1ns / 1ps

module gaussian_brush_mask_stamp_tb
  import gbms_pkg::*;
();

  // One byte step of the mask equals falloff * strength halves * ms / (65536 * 2 * 1000 / 400).
  localparam longint unsigned BYTE_STEP_DIV = 64'd327680;
  localparam int MAX_REPORTS = 10;
  localparam int WORDS_PER_PHASE = 250;
  localparam int PHASES = 8;

  // Clock and block inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [COORD_BITS-1:0] pixel_x = '0;
  logic [COORD_BITS-1:0] pixel_y = '0;
  logic [COORD_BITS-1:0] center_x = '0;
  logic [COORD_BITS-1:0] center_y = '0;
  logic erase = 1'b0;
  logic [MS_BITS-1:0] frame_ms = '0;
  logic done;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [BYTE_BITS-1:0] new_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gaussian_brush_mask_stamp uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .center_x(center_x),
    .center_y(center_y),
    .erase(erase),
    .frame_ms(frame_ms),
    .done(done),
    .out_x(out_x),
    .out_y(out_y),
    .new_value(new_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic                  erase;
    logic [MS_BITS-1:0]    ms;
  } brush_word_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BYTE_BITS-1:0]  value;
  } mask_update_t;

  typedef enum logic {ROW_WORD, ROW_REG} plan_kind_t;

  typedef struct {
    plan_kind_t               kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_data;
    brush_word_t              w;
    bit                       typed;
    logic [BYTE_BITS-1:0]     typed_val;
  } plan_row_t;

  // Predictor state: its own falloff table, mask copy and register copy.
  logic [FALL_BITS-1:0] weight_lut [FALLOFF_ENTRIES];
  byte unsigned painted_mask [int];
  logic [RADIUS_BITS-1:0] cur_radius = 11'd32;
  logic [STRENGTH_BITS-1:0] cur_strength = 6'd4;

  mask_update_t pending_updates [$];
  plan_row_t plan [$];

  int faults = 0;
  int reports = 0;
  int words_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int full_scale_hits = 0;
  int erased_to_zero = 0;

  // Random stamp walker state.
  logic [COORD_BITS-1:0] stamp_cx = '0;
  logic [COORD_BITS-1:0] stamp_cy = '0;
  int stamp_left = 0;
  bit stamp_erase = 1'b0;
  logic [COORD_BITS-1:0] recent_px [8];
  logic [COORD_BITS-1:0] recent_py [8];
  int recent_fill = 0;
  int recent_slot = 0;

  // Q0.16 weight for t2 = i / entries: series for exp(-t2/2), squared three times, less 0.1.
  function automatic logic [FALL_BITS-1:0] gauss_weight_q16(int i);
    longint unsigned z;
    longint unsigned term;
    longint unsigned e;
    longint          acc;
    longint          f;
    z = (longint'(i) << 30) / (2 * FALLOFF_ENTRIES);
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * z) >> 30) / longint'(k);
      acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    e = longint'(acc);
    repeat (3) e = (e * e + (64'd1 << 29)) >> 30;
    f = longint'(e) - 64'sd107374182;
    if (f < 0) f = 0;
    f = (f + (64'sd1 << 13)) >>> 14;
    if (f > 65535) f = 65535;
    return f[FALL_BITS-1:0];
  endfunction

  // Applies one brush word to the mask copy and returns the expected update.
  function automatic mask_update_t apply_brush(brush_word_t w);
    mask_update_t upd;
    longint unsigned px, py, cx, cy, dx, dy, d2, r, idx, f, p, q, old, v;
    int addr;
    px = longint'(w.px);
    py = longint'(w.py);
    cx = longint'(w.cx);
    cy = longint'(w.cy);
    upd.x = w.px;
    upd.y = w.py;
    upd.value = '0;
    if (px < MASK_SIZE && py < MASK_SIZE) begin
      dx = (px >= cx) ? px - cx : cx - px;
      dy = (py >= cy) ? py - cy : cy - py;
      d2 = dx * dx + dy * dy;
      r = (cur_radius == 0) ? 1 : longint'(cur_radius);
      idx = d2 * FALLOFF_ENTRIES / (r * r);
      f = (idx < FALLOFF_ENTRIES) ? longint'(weight_lut[idx]) : 0;
      p = f * longint'(cur_strength) * longint'(w.ms);
      addr = int'(py) * MASK_SIZE + int'(px);
      old = painted_mask.exists(addr) ? longint'(painted_mask[addr]) : 0;
      if (w.erase) begin
        q = (p + BYTE_STEP_DIV - 1) / BYTE_STEP_DIV;
        v = (q >= old) ? 0 : old - q;
        if (old != 0 && v == 0) erased_to_zero++;
      end else begin
        v = old + p / BYTE_STEP_DIV;
        if (v > 255) v = 255;
        if (v == 255) full_scale_hits++;
      end
      painted_mask[addr] = byte'(v);
      upd.value = v[BYTE_BITS-1:0];
    end
    return upd;
  endfunction

  function automatic logic [COORD_BITS-1:0] clip_coord(int v);
    if (v < 0) return '0;
    if (v > MASK_SIZE - 1) return COORD_BITS'(MASK_SIZE - 1);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic void plan_word(int px, int py, int cx, int cy, bit er, int ms,
                                    bit typed, int val);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.reg_idx = '0;
    row.reg_data = '0;
    row.w.px = px[COORD_BITS-1:0];
    row.w.py = py[COORD_BITS-1:0];
    row.w.cx = cx[COORD_BITS-1:0];
    row.w.cy = cy[COORD_BITS-1:0];
    row.w.erase = er;
    row.w.ms = ms[MS_BITS-1:0];
    row.typed = typed;
    row.typed_val = val[BYTE_BITS-1:0];
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    plan_row_t row;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_data = data;
    row.w = '{default: '0};
    row.typed = 1'b0;
    row.typed_val = '0;
    plan.push_back(row);
  endfunction

  // Presents one word and holds it until taken; the expectation is booked at the accept edge.
  // Called at a falling edge and returns at the next falling edge after acceptance.
  task automatic send_word(input brush_word_t w, input bit typed, input logic [BYTE_BITS-1:0] tval);
    mask_update_t upd;
    pixel_x <= w.px;
    pixel_y <= w.py;
    center_x <= w.cx;
    center_y <= w.cy;
    erase <= w.erase;
    frame_ms <= w.ms;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    upd = apply_brush(w);
    if (typed) upd.value = tval;
    pending_updates.push_back(upd);
    words_sent++;
    @(negedge clk);
  endtask

  // Drops start and waits until every booked result has come and the block is idle.
  task automatic wait_for_quiet();
    start <= 1'b0;
    @(negedge clk);
    while (pending_updates.size() != 0 || busy) @(negedge clk);
  endtask

  // Single-cycle register write; the predictor takes the value at the same edge.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_BRUSH_RADIUS: cur_radius = data[RADIUS_BITS-1:0];
      REG_STRENGTH:     cur_strength = data[STRENGTH_BITS-1:0];
      default:          ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly pixels of a stamp around a fixed centre, with revisits and some fully random noise.
  task automatic make_random_word(output brush_word_t w);
    int span;
    int roll;
    int slot;
    if (stamp_left == 0) begin
      if ($urandom_range(0, 99) < 20) begin
        stamp_cx = $urandom_range(0, 1) ? COORD_BITS'(MASK_SIZE - 1) : '0;
        stamp_cy = $urandom_range(0, 1) ? COORD_BITS'(MASK_SIZE - 1) : '0;
      end else begin
        stamp_cx = COORD_BITS'($urandom_range(0, MASK_SIZE - 1));
        stamp_cy = COORD_BITS'($urandom_range(0, MASK_SIZE - 1));
      end
      stamp_left = $urandom_range(4, 40);
      stamp_erase = ($urandom_range(0, 99) < 35);
    end
    stamp_left--;
    span = ((cur_radius == 0) ? 1 : int'(cur_radius)) + 2;
    if (span > MASK_SIZE - 1) span = MASK_SIZE - 1;
    roll = $urandom_range(0, 99);
    w.cx = stamp_cx;
    w.cy = stamp_cy;
    if (roll < 12) begin
      w.px = COORD_BITS'($urandom());
      w.py = COORD_BITS'($urandom());
      w.cx = COORD_BITS'($urandom());
      w.cy = COORD_BITS'($urandom());
    end else if (roll < 40 && recent_fill > 0) begin
      slot = $urandom_range(0, recent_fill - 1);
      w.px = recent_px[slot];
      w.py = recent_py[slot];
    end else begin
      w.px = clip_coord(int'(stamp_cx) + int'($urandom_range(0, 2 * span)) - span);
      w.py = clip_coord(int'(stamp_cy) + int'($urandom_range(0, 2 * span)) - span);
      recent_px[recent_slot] = w.px;
      recent_py[recent_slot] = w.py;
      recent_slot = (recent_slot + 1) % 8;
      if (recent_fill < 8) recent_fill++;
    end
    w.erase = ($urandom_range(0, 99) < 10) ? !stamp_erase : stamp_erase;
    roll = $urandom_range(0, 99);
    if (roll < 70) w.ms = MS_BITS'($urandom());
    else if (roll < 90) w.ms = MS_BITS'($urandom_range(0, 16));
    else w.ms = '1;
  endtask

  // Result checker: every strobe must match the oldest booked update.
  always @(posedge clk) begin
    mask_update_t exp_upd;
    if (!rst && done) begin
      results_seen++;
      if (pending_updates.size() == 0) begin
        faults++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("unexpected result word: x=%0d y=%0d value=%0d", out_x, out_y, new_value);
        end
      end else begin
        exp_upd = pending_updates.pop_front();
        if (out_x !== exp_upd.x || out_y !== exp_upd.y || new_value !== exp_upd.value) begin
          faults++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("result mismatch: expected x=%0d y=%0d value=%0d, got x=%0d y=%0d value=%0d",
                     exp_upd.x, exp_upd.y, exp_upd.value, out_x, out_y, new_value);
          end
        end
      end
    end
  end

  // Run limit: the slowest correct run, the clearing pass plus roughly 2000 words
  // with sender gaps, ends well before this timeout.
  initial begin
    #2_000_000;
    $display("gaussian_brush_mask_stamp_tb failed");
    $finish;
  end

  initial begin
    brush_word_t w;
    logic [CFG_DATA_BITS-1:0] phase_radius [PHASES];
    logic [CFG_DATA_BITS-1:0] phase_strength [PHASES];
    int idle_pct;
    int hold_at;
    int burst_left;
    int directed_words;

    for (int i = 0; i < FALLOFF_ENTRIES; i++) weight_lut[i] = gauss_weight_q16(i);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The block clears its mask after reset with busy high.
    wait_for_quiet();

    // Directed table. At the centre with reset settings one full paint stroke adds 183.
    plan_word(100, 100, 100, 100, 1'b0, 255, 1'b1, 183);
    plan_word(100, 100, 100, 100, 1'b0, 255, 1'b1, 255);
    plan_word(100, 100, 100, 100, 1'b1, 255, 1'b1, 71);
    plan_word(100, 100, 100, 100, 1'b1, 255, 1'b1, 0);
    plan_word(0, 0, 1023, 1023, 1'b1, 255, 1'b1, 0);
    plan_word(1023, 1023, 1023, 1023, 1'b0, 0, 1'b1, 0);
    plan_word(1023, 0, 1020, 3, 1'b0, 200, 1'b0, 0);
    plan_word(0, 1023, 5, 1020, 1'b0, 255, 1'b0, 0);
    // Exactly one radius away falls off the end of the table.
    plan_word(132, 100, 100, 100, 1'b0, 255, 1'b1, 0);
    plan_word(131, 100, 100, 100, 1'b0, 255, 1'b0, 0);
    // A zero radius behaves as radius one.
    plan_reg(REG_BRUSH_RADIUS, 11'd0);
    plan_word(500, 500, 500, 500, 1'b0, 255, 1'b1, 183);
    plan_word(501, 500, 500, 500, 1'b0, 255, 1'b1, 0);
    // Zero strength leaves the byte unchanged; upper data bits are not part of the register.
    plan_reg(REG_STRENGTH, 11'h7C0);
    plan_word(500, 500, 500, 500, 1'b0, 255, 1'b1, 183);
    plan_word(500, 500, 500, 500, 1'b1, 255, 1'b1, 183);
    plan_reg(REG_STRENGTH, 11'h03F);
    plan_word(500, 500, 500, 500, 1'b1, 255, 1'b1, 0);
    plan_word(500, 500, 500, 500, 1'b0, 1, 1'b1, 11);
    // Largest radius the register holds.
    plan_reg(REG_BRUSH_RADIUS, 11'h7FF);
    plan_word(0, 0, 1023, 1023, 1'b0, 255, 1'b0, 0);
    plan_word(1023, 1023, 0, 0, 1'b1, 128, 1'b0, 0);
    plan_reg(REG_BRUSH_RADIUS, 11'd1024);
    plan_reg(REG_STRENGTH, 11'd32);
    plan_word(700, 300, 680, 310, 1'b0, 77, 1'b0, 0);
    plan_word(700, 300, 680, 310, 1'b1, 3, 1'b0, 0);
    plan_reg(REG_BRUSH_RADIUS, 11'd1);
    plan_reg(REG_STRENGTH, 11'd2);
    plan_word(10, 10, 10, 10, 1'b0, 255, 1'b0, 0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_for_quiet();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].typed_val);
      end
    end
    directed_words = words_sent;

    // Register settings of the random phases, extremes first.
    phase_radius[0] = 11'd1;
    phase_radius[1] = 11'd1024;
    phase_radius[2] = 11'h7FF;
    phase_radius[3] = 11'd0;
    phase_radius[4] = CFG_DATA_BITS'($urandom_range(2, 48));
    phase_radius[5] = CFG_DATA_BITS'($urandom_range(1, 1024));
    phase_radius[6] = 11'd5;
    phase_radius[7] = CFG_DATA_BITS'($urandom_range(2, 64));
    phase_strength[0] = 11'd2;
    phase_strength[1] = 11'd32;
    phase_strength[2] = 11'd63;
    phase_strength[3] = 11'd32;
    phase_strength[4] = CFG_DATA_BITS'($urandom_range(2, 32));
    phase_strength[5] = CFG_DATA_BITS'($urandom_range(2, 32));
    phase_strength[6] = 11'd63;
    phase_strength[7] = CFG_DATA_BITS'($urandom_range(0, 63));

    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_quiet();
      write_reg(REG_BRUSH_RADIUS, phase_radius[ph]);
      // Random bits above the strength field ride along and must be dropped.
      write_reg(REG_STRENGTH,
                {(CFG_DATA_BITS - STRENGTH_BITS)'($urandom_range(0, 31)), 6'd0}
                | phase_strength[ph]);
      idle_pct = (ph < 3) ? 19 : (ph < 6) ? 75 : 0;
      hold_at = $urandom_range(20, WORDS_PER_PHASE - 20);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Once per phase the sender holds off until the block has drained.
        if (n == hold_at) wait_for_quiet();
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          burst_left = $urandom_range(10, 40);
        end else begin
          while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
          end
        end
        make_random_word(w);
        send_word(w, 1'b0, '0);
      end
    end

    // Drain with a bound, then allow the pipeline latency to expose stray results.
    start <= 1'b0;
    @(negedge clk);
    for (int n = 0; n < 2000 && pending_updates.size() != 0; n++) @(negedge clk);
    repeat (32) @(negedge clk);
    if (pending_updates.size() != 0) begin
      faults += pending_updates.size();
      $display("%0d booked results never arrived", pending_updates.size());
    end

    $display("Covered %0d words (%0d from the directed table) over %0d register writes; %0d results.",
             words_sent, directed_words, reg_writes, results_seen);
    $display("Paint reached full scale %0d times, erase cleared a nonzero byte %0d times, %0d faults.",
             full_scale_hits, erased_to_zero, faults);
    if (faults == 0) begin
      $display("gaussian_brush_mask_stamp_tb passed");
    end else begin
      $display("gaussian_brush_mask_stamp_tb failed");
    end
    $finish;
  end

endmodule
